// File: rtl/c2d_pkg.sv
// Shared types, codes and defaults for the 2D convolution block.
`default_nettype none
package c2d_pkg;

  localparam int DEF_MAX_ROWS   = 64;
  localparam int DEF_MAX_COLS   = 64;
  localparam int DEF_MAX_KERNEL = 5;

  localparam int POS_W = 9;

  localparam logic [1:0] ACT_TAP     = 2'd0;
  localparam logic [1:0] ACT_PIXEL   = 2'd1;
  localparam logic [1:0] ACT_COMPUTE = 2'd2;

  typedef enum logic [2:0] {
    REG_KERNEL_SIZE = 3'd0,
    REG_IN_HEIGHT   = 3'd1,
    REG_IN_WIDTH    = 3'd2,
    REG_OUT_HEIGHT  = 3'd3,
    REG_OUT_WIDTH   = 3'd4,
    REG_PAD_ROWS    = 3'd5,
    REG_PAD_COLS    = 3'd6,
    REG_ACCUMULATE  = 3'd7
  } reg_index_t;

  localparam logic [2:0] RST_KERNEL_SIZE = 3'd3;
  localparam logic [6:0] RST_IN_HEIGHT   = 7'd64;
  localparam logic [6:0] RST_IN_WIDTH    = 7'd64;
  localparam logic [6:0] RST_OUT_HEIGHT  = 7'd64;
  localparam logic [6:0] RST_OUT_WIDTH   = 7'd64;
  localparam logic [2:0] RST_PAD_ROWS    = 3'd1;
  localparam logic [2:0] RST_PAD_COLS    = 3'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

// File: rtl/c2d_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
`default_nettype none
module c2d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/conv2d_int8_padded_int16_accumulate.sv
// Top level of the stride-one int8 2D convolution with padding and 16-bit sum.
// Each input transaction stores a kernel tap, stores a source pixel, or asks
// for one output position. Stores, ignored codes and out-of-range positions
// leave the block idle. A compute transaction walks the K by K window one
// position per cycle through the single read port of the pixel memory, then
// passes the drain and done states (straight to done when K is zero); input
// stall stays high meanwhile. The result waits in an output register, and new
// transactions are taken while it is held.
`default_nettype none
module conv2d_int8_padded_int16_accumulate
  import c2d_pkg::*;
#(
  parameter int MAX_ROWS   = DEF_MAX_ROWS,
  parameter int MAX_COLS   = DEF_MAX_COLS,
  parameter int MAX_KERNEL = DEF_MAX_KERNEL
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         action,
  input  wire logic [4:0]         tap_index,
  input  wire logic signed [7:0]  tap_value,
  input  wire logic [5:0]         pixel_row,
  input  wire logic [5:0]         pixel_col,
  input  wire logic signed [7:0]  pixel_value,
  input  wire logic [6:0]         out_row,
  input  wire logic [6:0]         out_col,
  input  wire logic signed [15:0] prior_value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      sum
);

  localparam int PIX_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int PIX_AW    = (PIX_DEPTH > 1) ? $clog2(PIX_DEPTH) : 1;
  localparam int TAP_DEPTH = MAX_KERNEL * MAX_KERNEL;
  localparam int TAP_AW    = $clog2(TAP_DEPTH);
  localparam int KW        = $clog2(MAX_KERNEL + 1);

  logic [2:0] kernel_size;
  logic [6:0] in_height;
  logic [6:0] in_width;
  logic [6:0] out_height;
  logic [6:0] out_width;
  logic [2:0] pad_rows;
  logic [2:0] pad_cols;
  logic       accumulate;

  logic       cfg_write;
  reg_index_t cfg_sel;

  assign pready    = 1'b1;
  assign cfg_sel   = reg_index_t'(paddr[4:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_size <= RST_KERNEL_SIZE;
      in_height   <= RST_IN_HEIGHT;
      in_width    <= RST_IN_WIDTH;
      out_height  <= RST_OUT_HEIGHT;
      out_width   <= RST_OUT_WIDTH;
      pad_rows    <= RST_PAD_ROWS;
      pad_cols    <= RST_PAD_COLS;
      accumulate  <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_sel)
        REG_KERNEL_SIZE: kernel_size <= pwdata[2:0];
        REG_IN_HEIGHT:   in_height   <= pwdata[6:0];
        REG_IN_WIDTH:    in_width    <= pwdata[6:0];
        REG_OUT_HEIGHT:  out_height  <= pwdata[6:0];
        REG_OUT_WIDTH:   out_width   <= pwdata[6:0];
        REG_PAD_ROWS:    pad_rows    <= pwdata[2:0];
        REG_PAD_COLS:    pad_cols    <= pwdata[2:0];
        REG_ACCUMULATE:  accumulate  <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_KERNEL_SIZE: prdata = {29'd0, kernel_size};
      REG_IN_HEIGHT:   prdata = {25'd0, in_height};
      REG_IN_WIDTH:    prdata = {25'd0, in_width};
      REG_OUT_HEIGHT:  prdata = {25'd0, out_height};
      REG_OUT_WIDTH:   prdata = {25'd0, out_width};
      REG_PAD_ROWS:    prdata = {29'd0, pad_rows};
      REG_PAD_COLS:    prdata = {29'd0, pad_cols};
      REG_ACCUMULATE:  prdata = {31'd0, accumulate};
    endcase
  end

  state_t state;
  state_t state_next;

  logic                    in_accept;
  logic                    compute_in_range;
  logic                    start_compute;
  logic                    load_out;
  logic [KW-1:0]           k_eff;
  logic                    last_pos;
  logic [KW-1:0]           fh;
  logic [KW-1:0]           fw;
  logic signed [POS_W-1:0] ih;
  logic signed [POS_W-1:0] iw;
  logic signed [POS_W-1:0] iw_base;
  logic [TAP_AW-1:0]       tap_addr;
  logic                    pos_ok;
  logic signed [15:0]      acc;
  logic                    mac_pend;
  logic                    mac_ok;

  logic              tap_we;
  logic [TAP_AW-1:0] tap_waddr;
  logic [7:0]        tap_rdata;
  logic              pix_we;
  logic [PIX_AW-1:0] pix_waddr;
  logic [PIX_AW-1:0] pix_raddr;
  logic [7:0]        pix_rdata;

  assign in_accept        = in_valid && (state == ST_IDLE);
  assign compute_in_range = (out_row < out_height) && (out_col < out_width);
  assign start_compute    = in_accept && (action == ACT_COMPUTE) && compute_in_range;

  assign k_eff    = (int'(kernel_size) > MAX_KERNEL) ? KW'(MAX_KERNEL) : KW'(kernel_size);
  assign last_pos = (fh == k_eff - KW'(1)) && (fw == k_eff - KW'(1));

  assign pos_ok = (ih >= 0) && (int'(ih) < int'(in_height)) && (int'(ih) < MAX_ROWS)
               && (iw >= 0) && (int'(iw) < int'(in_width)) && (int'(iw) < MAX_COLS);
  assign pix_raddr = pos_ok ? PIX_AW'(int'(ih) * MAX_COLS + int'(iw)) : '0;

  assign tap_we    = in_accept && (action == ACT_TAP) && (int'(tap_index) < TAP_DEPTH);
  assign tap_waddr = TAP_AW'(tap_index);
  assign pix_we    = in_accept && (action == ACT_PIXEL)
                  && (int'(pixel_row) < MAX_ROWS) && (int'(pixel_col) < MAX_COLS);
  assign pix_waddr = PIX_AW'(int'(pixel_row) * MAX_COLS + int'(pixel_col));

  c2d_ram #(
    .WIDTH (8),
    .DEPTH (TAP_DEPTH)
  ) u_tap_ram (
    .clk   (clk),
    .we    (tap_we),
    .waddr (tap_waddr),
    .wdata (tap_value),
    .raddr (tap_addr),
    .rdata (tap_rdata)
  );

  c2d_ram #(
    .WIDTH (8),
    .DEPTH (PIX_DEPTH)
  ) u_pix_ram (
    .clk   (clk),
    .we    (pix_we),
    .waddr (pix_waddr),
    .wdata (pixel_value),
    .raddr (pix_raddr),
    .rdata (pix_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    load_out   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (start_compute) begin
          state_next = (k_eff == '0) ? ST_DONE : ST_RUN;
        end
      end
      ST_RUN: begin
        if (last_pos) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (start_compute) begin
      fh       <= '0;
      fw       <= '0;
      tap_addr <= '0;
      ih       <= $signed({2'b00, out_row}) - $signed({6'd0, pad_rows});
      iw       <= $signed({2'b00, out_col}) - $signed({6'd0, pad_cols});
      iw_base  <= $signed({2'b00, out_col}) - $signed({6'd0, pad_cols});
    end else if (state == ST_RUN) begin
      tap_addr <= tap_addr + TAP_AW'(1);
      if (fw == k_eff - KW'(1)) begin
        fw <= '0;
        fh <= fh + KW'(1);
        iw <= iw_base;
        ih <= ih + POS_W'(1);
      end else begin
        fw <= fw + KW'(1);
        iw <= iw + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mac_pend <= 1'b0;
    end else begin
      mac_pend <= (state == ST_RUN);
    end
    mac_ok <= pos_ok;
  end

  always_ff @(posedge clk) begin
    if (start_compute) begin
      acc <= accumulate ? prior_value : 16'sd0;
    end else if (mac_pend && mac_ok) begin
      acc <= acc + ($signed(pix_rdata) * $signed(tap_rdata));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      sum <= acc;
    end
  end

  a_mac_follows_run: assert property (@(posedge clk) disable iff (rst)
    mac_pend |-> $past(state == ST_RUN))
    else $error("multiply-accumulate without a preceding read");

  a_last_to_drain: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) && last_pos |=> (state == ST_DRAIN))
    else $error("window walk did not end at the last position");

  a_done_presents: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) && !out_valid |=> out_valid && (state == ST_IDLE))
    else $error("finished result was not presented");

  a_out_of_range_idle: assert property (@(posedge clk) disable iff (rst)
    in_accept && (action == ACT_COMPUTE) && !compute_in_range |=> (state == ST_IDLE))
    else $error("out-of-range position started a computation");

endmodule
`default_nettype wire

// File: dv/conv2d_int8_padded_int16_accumulate_tb.sv
// Self-checking testbench for the int8 2D convolution block with padding and 16-bit sum.
`timescale 1ns / 1ps
module conv2d_int8_padded_int16_accumulate_tb;
  import c2d_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int TAP_COUNT = DEF_MAX_KERNEL * DEF_MAX_KERNEL;
  localparam int PIXEL_COUNT = DEF_MAX_ROWS * DEF_MAX_COLS;
  localparam int TAP_IW = $clog2(TAP_COUNT);
  localparam int PIX_IW = $clog2(PIXEL_COUNT);
  localparam int ITEMS_PER_PHASE = 195;
  localparam int PHASE_COUNT = 10;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 1000000;

  typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct {
    bit [1:0]         action;
    bit [4:0]         tap_index;
    bit signed [7:0]  tap_value;
    bit [5:0]         pixel_row;
    bit [5:0]         pixel_col;
    bit signed [7:0]  pixel_value;
    bit [6:0]         out_row;
    bit [6:0]         out_col;
    bit signed [15:0] prior_value;
  } conv_item_t;

  typedef struct {
    bit [2:0]   ksize;
    bit [6:0]   in_rows;
    bit [6:0]   in_cols;
    bit [6:0]   out_rows;
    bit [6:0]   out_cols;
    bit [2:0]   pad_r;
    bit [2:0]   pad_c;
    bit         acc_mode;
    idle_mode_t mode;
  } phase_t;

  class conv_scoreboard;
    bit signed [7:0]  pixels [PIXEL_COUNT];
    bit signed [7:0]  taps [TAP_COUNT];
    bit [2:0]         ksize;
    bit [6:0]         in_rows;
    bit [6:0]         in_cols;
    bit [6:0]         out_rows;
    bit [6:0]         out_cols;
    bit [2:0]         pad_r;
    bit [2:0]         pad_c;
    bit               acc_mode;
    bit signed [15:0] expected_sums [$];
    int               errors;

    function new();
      ksize    = RST_KERNEL_SIZE;
      in_rows  = RST_IN_HEIGHT;
      in_cols  = RST_IN_WIDTH;
      out_rows = RST_OUT_HEIGHT;
      out_cols = RST_OUT_WIDTH;
      pad_r    = RST_PAD_ROWS;
      pad_c    = RST_PAD_COLS;
      acc_mode = 1'b0;
      errors   = 0;
    endfunction

    function void write_reg(reg_index_t idx, logic [31:0] value);
      case (idx)
        REG_KERNEL_SIZE: ksize = value[2:0];
        REG_IN_HEIGHT:   in_rows = value[6:0];
        REG_IN_WIDTH:    in_cols = value[6:0];
        REG_OUT_HEIGHT:  out_rows = value[6:0];
        REG_OUT_WIDTH:   out_cols = value[6:0];
        REG_PAD_ROWS:    pad_r = value[2:0];
        REG_PAD_COLS:    pad_c = value[2:0];
        REG_ACCUMULATE:  acc_mode = value[0];
        default: ;
      endcase
    endfunction

    function int kernel_side();
      return (ksize > DEF_MAX_KERNEL) ? DEF_MAX_KERNEL : int'(ksize);
    endfunction

    function int image_rows();
      return (in_rows > DEF_MAX_ROWS) ? DEF_MAX_ROWS : int'(in_rows);
    endfunction

    function int image_cols();
      return (in_cols > DEF_MAX_COLS) ? DEF_MAX_COLS : int'(in_cols);
    endfunction

    function bit signed [15:0] window_sum(conv_item_t it);
      int k;
      int r;
      int c;
      int p;
      int t;
      int acc;
      k = kernel_side();
      acc = acc_mode ? int'(it.prior_value) : 0;
      for (int fh = 0; fh < k; fh++) begin
        r = int'(it.out_row) + fh - int'(pad_r);
        if (r >= 0 && r < image_rows()) begin
          for (int fw = 0; fw < k; fw++) begin
            c = int'(it.out_col) + fw - int'(pad_c);
            if (c >= 0 && c < image_cols()) begin
              p = int'(pixels[PIX_IW'(r * DEF_MAX_COLS + c)]);
              t = int'(taps[TAP_IW'(fh * k + fw)]);
              acc += p * t;
            end
          end
        end
      end
      return acc[15:0];
    endfunction

    function void take_item(conv_item_t it);
      case (it.action)
        ACT_TAP: begin
          if (it.tap_index < TAP_COUNT) taps[it.tap_index] = it.tap_value;
        end
        ACT_PIXEL: begin
          pixels[PIX_IW'(int'(it.pixel_row) * DEF_MAX_COLS + int'(it.pixel_col))] =
            it.pixel_value;
        end
        ACT_COMPUTE: begin
          if (it.out_row < out_rows && it.out_col < out_cols)
            expected_sums.push_back(window_sum(it));
        end
        default: ;
      endcase
    endfunction

    function void check_sum(logic signed [15:0] got);
      bit signed [15:0] want;
      if (expected_sums.size() == 0) begin
        $error("sum: expected none, got %0d", got);
        errors++;
        return;
      end
      want = expected_sums.pop_front();
      if (got !== want) begin
        $error("sum: expected %0d, got %0d", want, got);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [4:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         action = '0;
  logic [4:0]         tap_index = '0;
  logic signed [7:0]  tap_value = '0;
  logic [5:0]         pixel_row = '0;
  logic [5:0]         pixel_col = '0;
  logic signed [7:0]  pixel_value = '0;
  logic [6:0]         out_row = '0;
  logic [6:0]         out_col = '0;
  logic signed [15:0] prior_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] sum;

  conv_scoreboard sb;
  bit   pix_loaded [PIXEL_COUNT];
  bit   tap_loaded [TAP_COUNT];
  int   send_pct = 0;
  int   recv_pct = 0;
  int   counted_items = 0;
  bit   hold_req = 1'b0;
  bit   hold_done = 1'b0;
  int   hold_left = 0;
  int   cycle_count = 0;

  conv2d_int8_padded_int16_accumulate i_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .tap_index(tap_index), .tap_value(tap_value),
    .pixel_row(pixel_row), .pixel_col(pixel_col), .pixel_value(pixel_value),
    .out_row(out_row), .out_col(out_col), .prior_value(prior_value),
    .out_valid(out_valid), .out_stall(out_stall), .sum(sum)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_sum(sum);
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_pct);
    end
  end

  function bit signed [7:0] pick_byte();
    case ($urandom_range(9))
      0: return -8'sd128;
      1: return 8'sd127;
      2: return 8'sd0;
      3: return -8'sd1;
      default: return 8'($urandom);
    endcase
  endfunction

  function bit signed [15:0] pick_word();
    case ($urandom_range(7))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return -16'sd1;
      default: return 16'($urandom);
    endcase
  endfunction

  function conv_item_t noise_item();
    conv_item_t it;
    it.action      = 2'($urandom);
    it.tap_index   = 5'($urandom);
    it.tap_value   = 8'($urandom);
    it.pixel_row   = 6'($urandom);
    it.pixel_col   = 6'($urandom);
    it.pixel_value = 8'($urandom);
    it.out_row     = 7'($urandom);
    it.out_col     = 7'($urandom);
    it.prior_value = 16'($urandom);
    return it;
  endfunction

  function phase_t phase_setting(int p);
    phase_t ph;
    case (p)
      0: ph = '{3'd2, 7'd8, 7'd8, 7'd9, 7'd9, 3'd1, 3'd1, 1'b0, IDLE_NONE};
      1: ph = '{3'd5, 7'd6, 7'd7, 7'd6, 7'd7, 3'd2, 3'd2, 1'b1, IDLE_SEND};
      2: ph = '{3'd5, 7'd1, 7'd1, 7'd5, 7'd5, 3'd4, 3'd4, 1'b1, IDLE_RECV};
      3: ph = '{3'd5, 7'd64, 7'd64, 7'd64, 7'd64, 3'd2, 3'd2, 1'b0, IDLE_BOTH};
      4: ph = '{3'd0, 7'd10, 7'd10, 7'd71, 7'd71, 3'd1, 3'd1, 1'b1, IDLE_NONE};
      5: ph = '{3'd6, 7'd0, 7'd127, 7'd127, 7'd127, 3'd0, 3'd7, 1'b0, IDLE_RECV};
      6: ph = '{3'd1, 7'd127, 7'd5, 7'd71, 7'd71, 3'd7, 3'd0, 1'b1, IDLE_BOTH};
      7: ph = '{3'd4, 7'd12, 7'd12, 7'd15, 7'd15, 3'd3, 3'd3, 1'b0, IDLE_SEND};
      8: ph = '{3'd3, 7'd16, 7'd16, 7'd16, 7'd16, 3'd1, 3'd1, 1'b1, IDLE_BOTH};
      default: ph = '{3'd7, 7'd9, 7'd11, 7'd13, 7'd15, 3'd4, 3'd3, 1'b0, IDLE_NONE};
    endcase
    return ph;
  endfunction

  task automatic apb_write(input reg_index_t idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, value);
  endtask

  task automatic apply_phase(input phase_t ph);
    apb_write(REG_KERNEL_SIZE, 32'(ph.ksize));
    apb_write(REG_IN_HEIGHT, 32'(ph.in_rows));
    apb_write(REG_IN_WIDTH, 32'(ph.in_cols));
    apb_write(REG_OUT_HEIGHT, 32'(ph.out_rows));
    apb_write(REG_OUT_WIDTH, 32'(ph.out_cols));
    apb_write(REG_PAD_ROWS, 32'(ph.pad_r));
    apb_write(REG_PAD_COLS, 32'(ph.pad_c));
    apb_write(REG_ACCUMULATE, 32'(ph.acc_mode));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (ph.mode)
      IDLE_SEND: begin send_pct = 88; recv_pct = 0; end
      IDLE_RECV: begin send_pct = 0; recv_pct = 88; end
      IDLE_BOTH: begin send_pct = 33; recv_pct = 33; end
      default:   begin send_pct = 0; recv_pct = 0; end
    endcase
  endtask

  task automatic send(input conv_item_t it);
    if (send_pct != 0 && $urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_pct);
    end
    in_valid    <= 1'b1;
    action      <= it.action;
    tap_index   <= it.tap_index;
    tap_value   <= it.tap_value;
    pixel_row   <= it.pixel_row;
    pixel_col   <= it.pixel_col;
    pixel_value <= it.pixel_value;
    out_row     <= it.out_row;
    out_col     <= it.out_col;
    prior_value <= it.prior_value;
    do @(posedge clk); while (in_stall);
    sb.take_item(it);
    if (!(it.action == ACT_UNUSED || (it.action == ACT_TAP && it.tap_index >= TAP_COUNT)))
      counted_items++;
  endtask

  task automatic load_tap(input int idx, input bit signed [7:0] value);
    conv_item_t it;
    it = noise_item();
    it.action    = ACT_TAP;
    it.tap_index = 5'(idx);
    it.tap_value = value;
    if (idx < TAP_COUNT) tap_loaded[TAP_IW'(idx)] = 1'b1;
    send(it);
  endtask

  task automatic load_pixel(input int r, input int c, input bit signed [7:0] value);
    conv_item_t it;
    it = noise_item();
    it.action      = ACT_PIXEL;
    it.pixel_row   = 6'(r);
    it.pixel_col   = 6'(c);
    it.pixel_value = value;
    pix_loaded[PIX_IW'(r * DEF_MAX_COLS + c)] = 1'b1;
    send(it);
  endtask

  // Every pixel and tap that the window reads is loaded first, since the
  // stores hold nothing defined until written.
  task automatic compute_at(input int orow, input int ocol, input bit signed [15:0] prior);
    conv_item_t it;
    int k;
    int r;
    int c;
    k = sb.kernel_side();
    if (orow < sb.out_rows && ocol < sb.out_cols) begin
      for (int fh = 0; fh < k; fh++) begin
        for (int fw = 0; fw < k; fw++) begin
          r = orow + fh - int'(sb.pad_r);
          c = ocol + fw - int'(sb.pad_c);
          if (r >= 0 && r < sb.image_rows() && c >= 0 && c < sb.image_cols()) begin
            if (!pix_loaded[PIX_IW'(r * DEF_MAX_COLS + c)]) load_pixel(r, c, pick_byte());
            if (!tap_loaded[TAP_IW'(fh * k + fw)]) load_tap(fh * k + fw, pick_byte());
          end
        end
      end
    end
    it = noise_item();
    it.action      = ACT_COMPUTE;
    it.out_row     = 7'(orow);
    it.out_col     = 7'(ocol);
    it.prior_value = prior;
    send(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_sums.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_directed();
    bit signed [7:0] first_taps [9];
    conv_item_t it;
    first_taps = '{8'sd127, 8'sd127, 8'sd0, 8'sd127, -8'sd128, -8'sd128, 8'sd1, -8'sd128,
                   8'sd127};
    for (int i = 0; i < 9; i++) load_tap(i, first_taps[4'(i)]);
    load_pixel(0, 0, -8'sd128);
    load_pixel(0, 1, -8'sd128);
    load_pixel(1, 0, -8'sd128);
    load_pixel(1, 1, 8'sd127);
    compute_at(0, 0, 16'sd32767);
    load_pixel(62, 62, 8'sd127);
    load_pixel(62, 63, 8'sd127);
    load_pixel(63, 62, 8'sd127);
    load_pixel(63, 63, -8'sd128);
    compute_at(63, 63, -16'sd32768);
    compute_at(64, 0, 16'sd0);
    compute_at(0, 127, 16'sd0);
    load_tap(31, -8'sd1);
    it = noise_item();
    it.action = ACT_UNUSED;
    send(it);
  endtask

  task automatic run_random(input int n);
    int pick;
    int rows;
    int cols;
    counted_items = 0;
    while (counted_items < n) begin
      pick = $urandom_range(99);
      rows = sb.image_rows();
      cols = sb.image_cols();
      if (pick < 34) begin
        compute_at($urandom_range(sb.out_rows - 1), $urandom_range(sb.out_cols - 1),
                   pick_word());
      end else if (pick < 40) begin
        compute_at($urandom_range(127), $urandom_range(127), pick_word());
      end else if (pick < 65 && rows != 0 && cols != 0) begin
        load_pixel($urandom_range(rows - 1), $urandom_range(cols - 1), pick_byte());
      end else if (pick < 75) begin
        load_pixel($urandom_range(63), $urandom_range(63), pick_byte());
      end else if (pick < 90) begin
        load_tap($urandom_range(TAP_COUNT - 1), pick_byte());
      end else if (pick < 96) begin
        load_tap($urandom_range(31, TAP_COUNT), pick_byte());
      end else begin
        compute_at($urandom_range(sb.out_rows - 1), $urandom_range(sb.out_cols - 1),
                   pick_word());
        load_tap($urandom_range(31, TAP_COUNT), pick_byte());
        send('{ACT_UNUSED, 5'($urandom), 8'($urandom), 6'($urandom), 6'($urandom),
               8'($urandom), 7'($urandom), 7'($urandom), 16'($urandom)});
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    drain();
    for (int p = 0; p < PHASE_COUNT; p++) begin
      apply_phase(phase_setting(p));
      if (p == 0) hold_req <= 1'b1;
      run_random(ITEMS_PER_PHASE);
      drain();
    end
    if (sb.expected_sums.size() != 0) begin
      $error("sum: expected %0d more results, got none", sb.expected_sums.size());
      sb.errors++;
    end
    if (sb.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
